>>> src/lbac_pkg.sv
package lbac_pkg;

    localparam int POOL_ENTRIES = 32;
    localparam int SLOT_W       = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int ID_W         = 48;
    localparam int ALIAS_W      = 16;
    localparam int IDX_W        = 5;
    localparam int CMD_W        = 3;
    localparam int FOLD_W       = 12;
    localparam int GEN_SHIFT    = 9;
    localparam int DATA_W       = ID_W + ALIAS_W;

    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [ALIAS_W-1:0] alias_t;
    typedef logic [FOLD_W-1:0]  fold_t;

    localparam link_t  NO_LINK  = '1;
    localparam alias_t NR_ALIAS = 16'hF000;
    localparam id_t    GEN_ADD  = 48'h1B0CA37ABA9;

    localparam logic CFG_SEED    = 1'b0;
    localparam logic CFG_NOTICE  = 1'b1;
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD, CMD_REMOVE, CMD_LOOKUP_ID, CMD_LOOKUP_ALIAS,
        CMD_RETRIEVE, CMD_NEXT_ID, CMD_GENERATE, CMD_CLEAR
    } cmd_t;

    typedef enum logic [1:0] {
        SCAN_ALIAS, SCAN_ID, SCAN_NEXT
    } scan_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CMD, ST_SCAN_RD, ST_SCAN_CMP, ST_UL_RD, ST_UL_WR,
        ST_AP_1, ST_AP_2, ST_DROP, ST_EMIT, ST_ADD_A, ST_ADD_ID, ST_ADD_B,
        ST_ADD_INS, ST_ADD_POP, ST_ADD_EV_RD, ST_ADD_EV, ST_ADD_WR, ST_ADD_ANS,
        ST_RM, ST_LK, ST_LK_ANS, ST_RT, ST_NX, ST_GEN, ST_GEN_CHK
    } state_t;

    function automatic logic link_ok(input link_t l);
        return !l[LINK_W-1];
    endfunction

    function automatic alias_t readback(input alias_t a);
        return ((a & NR_ALIAS) == NR_ALIAS) ? NR_ALIAS : a;
    endfunction

    function automatic fold_t seed_fold(input id_t s);
        return s[11:0] ^ s[23:12] ^ s[35:24] ^ s[47:36];
    endfunction

    function automatic id_t seed_step(input id_t s);
        return s + (s << GEN_SHIFT) + GEN_ADD;
    endfunction

endpackage

>>> src/lbac_ram.sv
module lbac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/lru_bidirectional_alias_cache_core.sv
// channel   | group  | contents
// ----------+--------+--------------------------------------------------------
// input     | s_*    | tuser: command; tdata: node_id, alias_req, slot_index
// result    | m_*    | tuser: kind; tdata: found, out_node_id, out_alias; tlast
// config    | cfg_*  | index 0 seed_init, index 1 removal_notice_enable
//
// one item at a time; a slot scan reads the slot ram once per slot, stepping
// through ST_SCAN_RD and ST_SCAN_CMP for each slot of a search command
// add runs up to two scans plus list updates; generate runs one
// scan per candidate alias; retrieve and clear run no scan
// reset clears per-entry valid bits, so invalid ram words read as reset values
// a stalled result holds in the output register; the next item is taken
// as soon as the final result of the current item is registered
module lru_bidirectional_alias_cache_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // node_id[47:0], alias_req[63:48], slot_index[68:64]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // found[0], out_node_id[48:1], out_alias[64:49]
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_wdata
);

    localparam int N = lbac_pkg::POOL_ENTRIES;

    // control state
    lbac_pkg::state_t     state_reg, state_next;
    lbac_pkg::state_t     sub_ret_reg, sub_ret_next;    // return after scan / unlink
    lbac_pkg::state_t     ap_ret_reg, ap_ret_next;      // return after append
    lbac_pkg::state_t     emit_ret_reg, emit_ret_next;  // return after a notice
    lbac_pkg::state_t     add_next_reg, add_next_next;  // add step after a drop
    lbac_pkg::scan_mode_t mode_reg, mode_next;
    logic [N-1:0]         in_use_reg, in_use_next;
    logic [N-1:0]         dvld_reg, dvld_next;          // slot data written
    logic [N-1:0]         nvld_reg, nvld_next;          // newer link written
    logic [N-1:0]         ovld_reg, ovld_next;          // older link written
    lbac_pkg::link_t      oldest_reg, oldest_next;
    lbac_pkg::link_t      newest_reg, newest_next;
    lbac_pkg::link_t      free_reg, free_next;
    lbac_pkg::id_t        seed_reg, seed_next;
    lbac_pkg::id_t        seed_init_reg, seed_init_next;
    logic                 notice_en_reg, notice_en_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 best_vld_reg, best_vld_next;

    // payload
    lbac_pkg::cmd_t       cmd_reg, cmd_next;
    lbac_pkg::id_t        id_reg, id_next;
    lbac_pkg::alias_t     alias_reg, alias_next;
    logic [lbac_pkg::IDX_W-1:0] idx_reg, idx_next;
    lbac_pkg::link_t      cnt_reg, cnt_next;
    lbac_pkg::link_t      hit_reg, hit_next;
    lbac_pkg::link_t      s_reg, s_next;
    lbac_pkg::alias_t     key_reg, key_next;
    lbac_pkg::id_t        hold_id_reg, hold_id_next;
    lbac_pkg::alias_t     hold_alias_reg, hold_alias_next;
    lbac_pkg::id_t        best_id_reg, best_id_next;
    lbac_pkg::alias_t     best_alias_reg, best_alias_next;
    logic                 em_kind_reg, em_kind_next;
    logic                 em_found_reg, em_found_next;
    lbac_pkg::id_t        em_id_reg, em_id_next;
    lbac_pkg::alias_t     em_alias_reg, em_alias_next;
    logic                 em_last_reg, em_last_next;
    logic                 m_kind_reg, m_kind_next;
    logic                 m_found_reg, m_found_next;
    lbac_pkg::id_t        m_id_reg, m_id_next;
    lbac_pkg::alias_t     m_alias_reg, m_alias_next;
    logic                 m_last_reg, m_last_next;

    // read-side bookkeeping, sampled with the ram read
    logic                 dvld_q_reg, nvld_q_reg, ovld_q_reg;
    lbac_pkg::slot_t      lra_q_reg;

    // ram ports
    logic                         data_we;
    lbac_pkg::slot_t              data_waddr, data_raddr;
    logic [lbac_pkg::DATA_W-1:0]  data_wdata, data_rdata;
    logic                         newer_we, older_we;
    lbac_pkg::slot_t              newer_waddr, older_waddr, link_raddr;
    lbac_pkg::link_t              newer_wdata, older_wdata, newer_rdata, older_rdata;

    lbac_pkg::slot_t   s_slot;
    lbac_pkg::id_t     rd_id;
    lbac_pkg::alias_t  rd_alias;
    lbac_pkg::link_t   newer_eff, older_eff;
    lbac_pkg::fold_t   gen_fold;
    lbac_pkg::alias_t  stored_alias;
    logic              out_free, hit_ok, free_ok, oldest_ok, add_bad, nr, idx_ok;
    logic              scan_end, slot_used, scan_match, scan_better;
    logic              launch, ans_zero;
    lbac_pkg::scan_mode_t launch_mode;
    lbac_pkg::state_t  launch_ret;
    lbac_pkg::alias_t  launch_key;

    lbac_ram #(.WIDTH(lbac_pkg::DATA_W), .DEPTH(N)) u_data_ram (
        .aclk(aclk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .raddr(data_raddr), .rdata(data_rdata)
    );

    lbac_ram #(.WIDTH(lbac_pkg::LINK_W), .DEPTH(N)) u_newer_ram (
        .aclk(aclk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
        .raddr(link_raddr), .rdata(newer_rdata)
    );

    lbac_ram #(.WIDTH(lbac_pkg::LINK_W), .DEPTH(N)) u_older_ram (
        .aclk(aclk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
        .raddr(link_raddr), .rdata(older_rdata)
    );

    // decoded conditions
    assign s_slot    = s_reg[lbac_pkg::SLOT_W-1:0];
    assign rd_id     = dvld_q_reg ? data_rdata[lbac_pkg::ID_W-1:0] : '0;
    assign rd_alias  = dvld_q_reg ? data_rdata[lbac_pkg::DATA_W-1:lbac_pkg::ID_W] : '0;
    // never-written links read as the reset layout of the free list
    assign newer_eff = nvld_q_reg ? newer_rdata : lbac_pkg::NO_LINK;
    assign older_eff = ovld_q_reg ? older_rdata :
                       (lra_q_reg == '0) ? lbac_pkg::NO_LINK :
                       lbac_pkg::LINK_W'(lra_q_reg) - lbac_pkg::LINK_W'(1);
    assign gen_fold  = lbac_pkg::seed_fold(seed_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign hit_ok    = lbac_pkg::link_ok(hit_reg);
    assign free_ok   = lbac_pkg::link_ok(free_reg);
    assign oldest_ok = lbac_pkg::link_ok(oldest_reg);
    assign add_bad   = (id_reg == '0) || (alias_reg == '0);
    assign nr        = ((alias_reg & lbac_pkg::NR_ALIAS) == lbac_pkg::NR_ALIAS);
    assign idx_ok    = 32'(idx_reg) < N;
    assign stored_alias = nr ? (lbac_pkg::NR_ALIAS | lbac_pkg::ALIAS_W'(s_slot)) : alias_reg;
    assign scan_end  = (cnt_reg == lbac_pkg::LINK_W'(N));
    assign slot_used = in_use_reg[cnt_reg[lbac_pkg::SLOT_W-1:0]];
    assign scan_match = slot_used &&
        (((mode_reg == lbac_pkg::SCAN_ALIAS) && (key_reg != '0) && (rd_alias == key_reg)) ||
         ((mode_reg == lbac_pkg::SCAN_ID) && (rd_id == id_reg)));
    assign scan_better = slot_used && (mode_reg == lbac_pkg::SCAN_NEXT) &&
        (rd_id > id_reg) && (!best_vld_reg || (rd_id < best_id_reg));

    assign s_tready = (state_reg == lbac_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_alias_reg, m_id_reg, m_found_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbac_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lbac_pkg::ST_CMD;
            end
            lbac_pkg::ST_CMD: begin
                case (cmd_reg)
                    lbac_pkg::CMD_ADD: begin
                        if (add_bad) state_next = lbac_pkg::ST_EMIT;
                        else if (nr) state_next = lbac_pkg::ST_ADD_ID;
                        else state_next = lbac_pkg::ST_SCAN_RD;
                    end
                    lbac_pkg::CMD_REMOVE, lbac_pkg::CMD_LOOKUP_ID,
                    lbac_pkg::CMD_LOOKUP_ALIAS, lbac_pkg::CMD_NEXT_ID:
                        state_next = lbac_pkg::ST_SCAN_RD;
                    lbac_pkg::CMD_RETRIEVE:
                        state_next = idx_ok ? lbac_pkg::ST_RT : lbac_pkg::ST_EMIT;
                    lbac_pkg::CMD_GENERATE: state_next = lbac_pkg::ST_GEN;
                    lbac_pkg::CMD_CLEAR:    state_next = lbac_pkg::ST_EMIT;
                    default:                state_next = lbac_pkg::ST_IDLE;
                endcase
            end
            lbac_pkg::ST_SCAN_RD: state_next = scan_end ? sub_ret_reg : lbac_pkg::ST_SCAN_CMP;
            lbac_pkg::ST_SCAN_CMP: state_next = scan_match ? sub_ret_reg : lbac_pkg::ST_SCAN_RD;
            lbac_pkg::ST_UL_RD: state_next = lbac_pkg::ST_UL_WR;
            lbac_pkg::ST_UL_WR: state_next = sub_ret_reg;
            lbac_pkg::ST_AP_1:  state_next = lbac_pkg::ST_AP_2;
            lbac_pkg::ST_AP_2:  state_next = ap_ret_reg;
            lbac_pkg::ST_DROP: begin
                if (cmd_reg == lbac_pkg::CMD_REMOVE || notice_en_reg)
                    state_next = lbac_pkg::ST_EMIT;
                else
                    state_next = add_next_reg;
            end
            lbac_pkg::ST_EMIT: begin
                if (out_free) state_next = em_last_reg ? lbac_pkg::ST_IDLE : emit_ret_reg;
            end
            lbac_pkg::ST_ADD_A: state_next = hit_ok ? lbac_pkg::ST_UL_RD : lbac_pkg::ST_ADD_ID;
            lbac_pkg::ST_ADD_ID: state_next = lbac_pkg::ST_SCAN_RD;
            lbac_pkg::ST_ADD_B: state_next = hit_ok ? lbac_pkg::ST_UL_RD : lbac_pkg::ST_ADD_INS;
            lbac_pkg::ST_ADD_INS: begin
                if (free_ok) state_next = lbac_pkg::ST_ADD_POP;
                else if (oldest_ok) state_next = lbac_pkg::ST_UL_RD;
                else state_next = lbac_pkg::ST_EMIT;
            end
            lbac_pkg::ST_ADD_POP:   state_next = lbac_pkg::ST_ADD_WR;
            lbac_pkg::ST_ADD_EV_RD: state_next = lbac_pkg::ST_ADD_EV;
            lbac_pkg::ST_ADD_EV:
                state_next = notice_en_reg ? lbac_pkg::ST_EMIT : lbac_pkg::ST_ADD_WR;
            lbac_pkg::ST_ADD_WR:  state_next = lbac_pkg::ST_AP_1;
            lbac_pkg::ST_ADD_ANS: state_next = lbac_pkg::ST_EMIT;
            lbac_pkg::ST_RM: state_next = hit_ok ? lbac_pkg::ST_UL_RD : lbac_pkg::ST_EMIT;
            lbac_pkg::ST_LK: begin
                if (!hit_ok) state_next = lbac_pkg::ST_EMIT;
                else if (newest_reg == hit_reg) state_next = lbac_pkg::ST_LK_ANS;
                else state_next = lbac_pkg::ST_UL_RD;
            end
            lbac_pkg::ST_LK_ANS: state_next = lbac_pkg::ST_EMIT;
            lbac_pkg::ST_RT:     state_next = lbac_pkg::ST_EMIT;
            lbac_pkg::ST_NX:     state_next = lbac_pkg::ST_EMIT;
            lbac_pkg::ST_GEN:
                state_next = (gen_fold == '0) ? lbac_pkg::ST_GEN : lbac_pkg::ST_SCAN_RD;
            lbac_pkg::ST_GEN_CHK: begin
                if (!hit_ok) state_next = lbac_pkg::ST_EMIT;
                else if (newest_reg == hit_reg) state_next = lbac_pkg::ST_GEN;
                else state_next = lbac_pkg::ST_UL_RD;
            end
            default: state_next = lbac_pkg::ST_IDLE;
        endcase
    end

    // datapath, ram ports and outputs
    always_comb begin
        sub_ret_next    = sub_ret_reg;
        ap_ret_next     = ap_ret_reg;
        emit_ret_next   = emit_ret_reg;
        add_next_next   = add_next_reg;
        mode_next       = mode_reg;
        in_use_next     = in_use_reg;
        dvld_next       = dvld_reg;
        nvld_next       = nvld_reg;
        ovld_next       = ovld_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        free_next       = free_reg;
        seed_next       = seed_reg;
        seed_init_next  = seed_init_reg;
        notice_en_next  = notice_en_reg;
        best_vld_next   = best_vld_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        alias_next      = alias_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        s_next          = s_reg;
        key_next        = key_reg;
        hold_id_next    = hold_id_reg;
        hold_alias_next = hold_alias_reg;
        best_id_next    = best_id_reg;
        best_alias_next = best_alias_reg;
        em_kind_next    = em_kind_reg;
        em_found_next   = em_found_reg;
        em_id_next      = em_id_reg;
        em_alias_next   = em_alias_reg;
        em_last_next    = em_last_reg;
        m_kind_next     = m_kind_reg;
        m_found_next    = m_found_reg;
        m_id_next       = m_id_reg;
        m_alias_next    = m_alias_reg;
        m_last_next     = m_last_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        data_we     = 1'b0;
        data_waddr  = s_slot;
        data_wdata  = {stored_alias, id_reg};
        data_raddr  = cnt_reg[lbac_pkg::SLOT_W-1:0];
        newer_we    = 1'b0;
        newer_waddr = s_slot;
        newer_wdata = lbac_pkg::NO_LINK;
        older_we    = 1'b0;
        older_waddr = s_slot;
        older_wdata = free_reg;
        link_raddr  = s_slot;

        launch      = 1'b0;
        launch_mode = lbac_pkg::SCAN_ALIAS;
        launch_ret  = lbac_pkg::ST_IDLE;
        launch_key  = alias_reg;
        ans_zero    = 1'b0;

        case (state_reg)
            lbac_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = lbac_pkg::cmd_t'(s_tuser);
                    id_next    = s_tdata[47:0];
                    alias_next = s_tdata[63:48];
                    idx_next   = s_tdata[68:64];
                end
            end
            lbac_pkg::ST_CMD: begin
                case (cmd_reg)
                    lbac_pkg::CMD_ADD: begin
                        if (add_bad) begin
                            ans_zero = 1'b1;
                        end else if (!nr) begin
                            launch     = 1'b1;
                            launch_ret = lbac_pkg::ST_ADD_A;
                        end
                    end
                    lbac_pkg::CMD_REMOVE: begin
                        launch     = 1'b1;
                        launch_ret = lbac_pkg::ST_RM;
                    end
                    lbac_pkg::CMD_LOOKUP_ID: begin
                        launch      = 1'b1;
                        launch_mode = lbac_pkg::SCAN_ID;
                        launch_ret  = lbac_pkg::ST_LK;
                    end
                    lbac_pkg::CMD_LOOKUP_ALIAS: begin
                        launch     = 1'b1;
                        launch_ret = lbac_pkg::ST_LK;
                    end
                    lbac_pkg::CMD_RETRIEVE: begin
                        data_raddr = lbac_pkg::SLOT_W'(idx_reg);
                        if (!idx_ok) ans_zero = 1'b1;
                    end
                    lbac_pkg::CMD_NEXT_ID: begin
                        launch      = 1'b1;
                        launch_mode = lbac_pkg::SCAN_NEXT;
                        launch_ret  = lbac_pkg::ST_NX;
                    end
                    lbac_pkg::CMD_CLEAR: begin
                        // rebuild free and age lists; ids, aliases and seed stay
                        in_use_next = '0;
                        nvld_next   = '0;
                        ovld_next   = '0;
                        oldest_next = lbac_pkg::NO_LINK;
                        newest_next = lbac_pkg::NO_LINK;
                        free_next   = lbac_pkg::LINK_W'(N - 1);
                        ans_zero    = 1'b1;
                    end
                    default: ;
                endcase
            end
            lbac_pkg::ST_SCAN_CMP: begin
                if (scan_match) begin
                    hit_next        = cnt_reg;
                    hold_id_next    = rd_id;
                    hold_alias_next = rd_alias;
                end else begin
                    cnt_next = cnt_reg + lbac_pkg::LINK_W'(1);
                end
                if (scan_better) begin
                    best_vld_next   = 1'b1;
                    best_id_next    = rd_id;
                    best_alias_next = rd_alias;
                end
            end
            lbac_pkg::ST_UL_WR: begin
                // unlink s from the age list
                if (lbac_pkg::link_ok(newer_eff)) begin
                    older_we    = 1'b1;
                    older_waddr = newer_eff[lbac_pkg::SLOT_W-1:0];
                    older_wdata = older_eff;
                end
                if (lbac_pkg::link_ok(older_eff)) begin
                    newer_we    = 1'b1;
                    newer_waddr = older_eff[lbac_pkg::SLOT_W-1:0];
                    newer_wdata = newer_eff;
                end
                if (newest_reg == s_reg) newest_next = older_eff;
                if (oldest_reg == s_reg) oldest_next = newer_eff;
            end
            lbac_pkg::ST_AP_1: begin
                older_we    = 1'b1;
                older_wdata = newest_reg;
                if (lbac_pkg::link_ok(newest_reg)) begin
                    newer_we    = 1'b1;
                    newer_waddr = newest_reg[lbac_pkg::SLOT_W-1:0];
                    newer_wdata = s_reg;
                end
            end
            lbac_pkg::ST_AP_2: begin
                newer_we = 1'b1;
                if (!lbac_pkg::link_ok(newest_reg)) oldest_next = s_reg;
                newest_next = s_reg;
            end
            lbac_pkg::ST_DROP: begin
                // push the unlinked slot on the free list, id cleared
                in_use_next[s_slot] = 1'b0;
                data_we     = 1'b1;
                data_wdata  = {hold_alias_reg, lbac_pkg::ID_W'(0)};
                newer_we    = 1'b1;
                older_we    = 1'b1;
                free_next   = s_reg;
                em_id_next    = hold_id_reg;
                em_alias_next = lbac_pkg::readback(hold_alias_reg);
                if (cmd_reg == lbac_pkg::CMD_REMOVE) begin
                    em_kind_next  = lbac_pkg::KIND_ANSWER;
                    em_found_next = 1'b1;
                    em_last_next  = 1'b1;
                end else begin
                    em_kind_next  = lbac_pkg::KIND_NOTICE;
                    em_found_next = 1'b0;
                    em_last_next  = 1'b0;
                    emit_ret_next = add_next_reg;
                end
            end
            lbac_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = em_kind_reg;
                    m_found_next  = em_found_reg;
                    m_id_next     = em_id_reg;
                    m_alias_next  = em_alias_reg;
                    m_last_next   = em_last_reg;
                end
            end
            lbac_pkg::ST_ADD_A: begin
                s_next        = hit_reg;
                sub_ret_next  = lbac_pkg::ST_DROP;
                add_next_next = lbac_pkg::ST_ADD_ID;
            end
            lbac_pkg::ST_ADD_ID: begin
                launch      = 1'b1;
                launch_mode = lbac_pkg::SCAN_ID;
                launch_ret  = lbac_pkg::ST_ADD_B;
            end
            lbac_pkg::ST_ADD_B: begin
                s_next        = hit_reg;
                sub_ret_next  = lbac_pkg::ST_DROP;
                add_next_next = lbac_pkg::ST_ADD_INS;
            end
            lbac_pkg::ST_ADD_INS: begin
                if (free_ok) begin
                    s_next     = free_reg;
                    link_raddr = free_reg[lbac_pkg::SLOT_W-1:0];
                end else if (oldest_ok) begin
                    // evict the oldest mapping
                    s_next       = oldest_reg;
                    sub_ret_next = lbac_pkg::ST_ADD_EV_RD;
                end else begin
                    ans_zero = 1'b1;
                end
            end
            lbac_pkg::ST_ADD_POP: free_next = older_eff;
            lbac_pkg::ST_ADD_EV_RD: data_raddr = s_slot;
            lbac_pkg::ST_ADD_EV: begin
                em_kind_next  = lbac_pkg::KIND_NOTICE;
                em_found_next = 1'b0;
                em_id_next    = rd_id;
                em_alias_next = lbac_pkg::readback(rd_alias);
                em_last_next  = 1'b0;
                emit_ret_next = lbac_pkg::ST_ADD_WR;
            end
            lbac_pkg::ST_ADD_WR: begin
                data_we             = 1'b1;
                in_use_next[s_slot] = 1'b1;
                ap_ret_next         = lbac_pkg::ST_ADD_ANS;
            end
            lbac_pkg::ST_ADD_ANS: begin
                em_kind_next  = lbac_pkg::KIND_ANSWER;
                em_found_next = 1'b1;
                em_id_next    = id_reg;
                em_alias_next = lbac_pkg::readback(stored_alias);
                em_last_next  = 1'b1;
            end
            lbac_pkg::ST_RM: begin
                s_next       = hit_reg;
                sub_ret_next = lbac_pkg::ST_DROP;
                if (!hit_ok) ans_zero = 1'b1;
            end
            lbac_pkg::ST_LK: begin
                s_next       = hit_reg;
                sub_ret_next = lbac_pkg::ST_AP_1;
                ap_ret_next  = lbac_pkg::ST_LK_ANS;
                if (!hit_ok) ans_zero = 1'b1;
            end
            lbac_pkg::ST_LK_ANS: begin
                em_kind_next  = lbac_pkg::KIND_ANSWER;
                em_found_next = 1'b1;
                em_id_next    = hold_id_reg;
                em_alias_next = lbac_pkg::readback(hold_alias_reg);
                em_last_next  = 1'b1;
            end
            lbac_pkg::ST_RT: begin
                // stale data of a free slot still counts while its alias is set
                if (rd_alias != '0) begin
                    em_kind_next  = lbac_pkg::KIND_ANSWER;
                    em_found_next = 1'b1;
                    em_id_next    = rd_id;
                    em_alias_next = lbac_pkg::readback(rd_alias);
                    em_last_next  = 1'b1;
                end else begin
                    ans_zero = 1'b1;
                end
            end
            lbac_pkg::ST_NX: begin
                if (best_vld_reg) begin
                    em_kind_next  = lbac_pkg::KIND_ANSWER;
                    em_found_next = 1'b1;
                    em_id_next    = best_id_reg;
                    em_alias_next = lbac_pkg::readback(best_alias_reg);
                    em_last_next  = 1'b1;
                end else begin
                    ans_zero = 1'b1;
                end
            end
            lbac_pkg::ST_GEN: begin
                seed_next = lbac_pkg::seed_step(seed_reg);
                if (gen_fold != '0) begin
                    launch     = 1'b1;
                    launch_key = lbac_pkg::ALIAS_W'(gen_fold);
                    launch_ret = lbac_pkg::ST_GEN_CHK;
                end
            end
            lbac_pkg::ST_GEN_CHK: begin
                // a used candidate is touched, then the next seed is tried
                s_next       = hit_reg;
                sub_ret_next = lbac_pkg::ST_AP_1;
                ap_ret_next  = lbac_pkg::ST_GEN;
                if (!hit_ok) begin
                    em_kind_next  = lbac_pkg::KIND_ANSWER;
                    em_found_next = 1'b0;
                    em_id_next    = '0;
                    em_alias_next = key_reg;
                    em_last_next  = 1'b1;
                end
            end
            default: ;
        endcase

        if (launch) begin
            cnt_next      = '0;
            hit_next      = lbac_pkg::NO_LINK;
            best_vld_next = 1'b0;
            mode_next     = launch_mode;
            key_next      = launch_key;
            sub_ret_next  = launch_ret;
        end

        if (ans_zero) begin
            em_kind_next  = lbac_pkg::KIND_ANSWER;
            em_found_next = 1'b0;
            em_id_next    = '0;
            em_alias_next = '0;
            em_last_next  = 1'b1;
        end

        // every ram write marks its entry as written
        if (data_we)  dvld_next[data_waddr]  = 1'b1;
        if (newer_we) nvld_next[newer_waddr] = 1'b1;
        if (older_we) ovld_next[older_waddr] = 1'b1;

        if (cfg_we) begin
            if (cfg_index == lbac_pkg::CFG_SEED) begin
                seed_init_next = cfg_wdata;
                seed_next      = cfg_wdata;
            end else begin
                notice_en_next = cfg_wdata[0];
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lbac_pkg::ST_IDLE;
            in_use_reg    <= '0;
            dvld_reg      <= '0;
            nvld_reg      <= '0;
            ovld_reg      <= '0;
            oldest_reg    <= lbac_pkg::NO_LINK;
            newest_reg    <= lbac_pkg::NO_LINK;
            free_reg      <= lbac_pkg::LINK_W'(N - 1);
            seed_reg      <= '0;
            seed_init_reg <= '0;
            notice_en_reg <= 1'b1;
            m_tvalid_reg  <= 1'b0;
            best_vld_reg  <= 1'b0;
            sub_ret_reg   <= lbac_pkg::ST_IDLE;
            ap_ret_reg    <= lbac_pkg::ST_IDLE;
            emit_ret_reg  <= lbac_pkg::ST_IDLE;
            add_next_reg  <= lbac_pkg::ST_IDLE;
            mode_reg      <= lbac_pkg::SCAN_ALIAS;
        end else begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            dvld_reg      <= dvld_next;
            nvld_reg      <= nvld_next;
            ovld_reg      <= ovld_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            free_reg      <= free_next;
            seed_reg      <= seed_next;
            seed_init_reg <= seed_init_next;
            notice_en_reg <= notice_en_next;
            m_tvalid_reg  <= m_tvalid_next;
            best_vld_reg  <= best_vld_next;
            sub_ret_reg   <= sub_ret_next;
            ap_ret_reg    <= ap_ret_next;
            emit_ret_reg  <= emit_ret_next;
            add_next_reg  <= add_next_next;
            mode_reg      <= mode_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        alias_reg      <= alias_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        hit_reg        <= hit_next;
        s_reg          <= s_next;
        key_reg        <= key_next;
        hold_id_reg    <= hold_id_next;
        hold_alias_reg <= hold_alias_next;
        best_id_reg    <= best_id_next;
        best_alias_reg <= best_alias_next;
        em_kind_reg    <= em_kind_next;
        em_found_reg   <= em_found_next;
        em_id_reg      <= em_id_next;
        em_alias_reg   <= em_alias_next;
        em_last_reg    <= em_last_next;
        m_kind_reg     <= m_kind_next;
        m_found_reg    <= m_found_next;
        m_id_reg       <= m_id_next;
        m_alias_reg    <= m_alias_next;
        m_last_reg     <= m_last_next;
        dvld_q_reg     <= dvld_reg[data_raddr];
        nvld_q_reg     <= nvld_reg[link_raddr];
        ovld_q_reg     <= ovld_reg[link_raddr];
        lra_q_reg      <= link_raddr;
    end

    // the free list head is never a slot in use
    a_free_head_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        free_ok |-> !in_use_reg[free_reg[lbac_pkg::SLOT_W-1:0]])
        else $error("free list head is in use");

    // both ends of the age list are present or both absent
    a_age_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest_ok == lbac_pkg::link_ok(newest_reg))
        else $error("age list ends disagree");

    // the newest entry is always in use
    a_newest_used: assert property (@(posedge aclk) disable iff (!aresetn)
        lbac_pkg::link_ok(newest_reg) |-> in_use_reg[newest_reg[lbac_pkg::SLOT_W-1:0]])
        else $error("newest slot not in use");

    // the sequencer leaves idle only on an accepted item
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lbac_pkg::ST_IDLE && !s_tvalid) |=> state_reg == lbac_pkg::ST_IDLE)
        else $error("left idle without an item");

endmodule

>>> test/lru_bidirectional_alias_cache_core_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic             kind;
    logic             found;
    lbac_pkg::id_t    node;
    lbac_pkg::alias_t name;
    logic             last;
} cache_reply_t;

// tracks the cache contents and holds the replies still owed by the block
class alias_cache_scoreboard;
    lbac_pkg::id_t    node_of [lbac_pkg::POOL_ENTRIES];
    lbac_pkg::alias_t alias_of[lbac_pkg::POOL_ENTRIES];
    bit               used    [lbac_pkg::POOL_ENTRIES];
    lbac_pkg::link_t  newer   [lbac_pkg::POOL_ENTRIES];
    lbac_pkg::link_t  older   [lbac_pkg::POOL_ENTRIES];
    lbac_pkg::link_t  oldest, newest, free_top;
    lbac_pkg::id_t    seed;
    bit               notice_en;
    cache_reply_t     owed[$];
    int               errors;

    function bit live(lbac_pkg::link_t l);
        return l < lbac_pkg::POOL_ENTRIES;
    endfunction

    function lbac_pkg::alias_t shown(lbac_pkg::alias_t a);
        return (a[15:12] == 4'hF) ? lbac_pkg::NR_ALIAS : a;
    endfunction

    function void rebuild();
        for (int i = 0; i < lbac_pkg::POOL_ENTRIES; i++) begin
            used[i]  = 0;
            newer[i] = lbac_pkg::NO_LINK;
            older[i] = (i == 0) ? lbac_pkg::NO_LINK : lbac_pkg::link_t'(i - 1);
        end
        oldest   = lbac_pkg::NO_LINK;
        newest   = lbac_pkg::NO_LINK;
        free_top = lbac_pkg::link_t'(lbac_pkg::POOL_ENTRIES - 1);
    endfunction

    function void power_up();
        for (int i = 0; i < lbac_pkg::POOL_ENTRIES; i++) begin
            node_of[i]  = '0;
            alias_of[i] = '0;
        end
        rebuild();
        seed      = '0;
        notice_en = 1;
        errors    = 0;
    endfunction

    function void write_reg(logic idx, lbac_pkg::id_t val);
        if (idx == lbac_pkg::CFG_SEED) seed = val;
        else notice_en = val[0];
    endfunction

    function void unlink(lbac_pkg::link_t s);
        lbac_pkg::link_t n, o;
        n = newer[s];
        o = older[s];
        if (live(n)) older[n] = o;
        if (live(o)) newer[o] = n;
        if (newest == s) newest = o;
        if (oldest == s) oldest = n;
    endfunction

    function void make_newest(lbac_pkg::link_t s);
        newer[s] = lbac_pkg::NO_LINK;
        older[s] = newest;
        if (live(newest)) newer[newest] = s;
        else oldest = s;
        newest = s;
    endfunction

    function void touch(lbac_pkg::link_t s);
        if (newest != s) begin
            unlink(s);
            make_newest(s);
        end
    endfunction

    function void release_slot(lbac_pkg::link_t s);
        unlink(s);
        used[s]    = 0;
        node_of[s] = '0;
        newer[s]   = lbac_pkg::NO_LINK;
        older[s]   = free_top;
        free_top   = s;
    endfunction

    function lbac_pkg::link_t by_alias(lbac_pkg::alias_t a);
        if (a == 0) return lbac_pkg::NO_LINK;
        for (int i = 0; i < lbac_pkg::POOL_ENTRIES; i++)
            if (used[i] && alias_of[i] == a) return lbac_pkg::link_t'(i);
        return lbac_pkg::NO_LINK;
    endfunction

    function lbac_pkg::link_t by_node(lbac_pkg::id_t id);
        for (int i = 0; i < lbac_pkg::POOL_ENTRIES; i++)
            if (used[i] && node_of[i] == id) return lbac_pkg::link_t'(i);
        return lbac_pkg::NO_LINK;
    endfunction

    function void owe(logic kind, logic found, lbac_pkg::id_t node, lbac_pkg::alias_t name);
        cache_reply_t r;
        r.kind  = kind;
        r.found = found;
        r.node  = node;
        r.name  = name;
        r.last  = 0;
        owed.push_back(r);
    endfunction

    // drop an entry on behalf of add, with a notice when enabled
    function void drop_for_add(lbac_pkg::link_t s);
        lbac_pkg::id_t    n;
        lbac_pkg::alias_t a;
        n = node_of[s];
        a = shown(alias_of[s]);
        release_slot(s);
        if (notice_en) owe(lbac_pkg::KIND_NOTICE, 0, n, a);
    endfunction

    function void add_entry(lbac_pkg::id_t id, lbac_pkg::alias_t a);
        lbac_pkg::link_t  s, ins;
        bit               nr;
        lbac_pkg::alias_t keep;
        if (id == 0 || a == 0) begin
            owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            return;
        end
        nr = (a[15:12] == 4'hF);
        if (!nr) begin
            s = by_alias(a);
            if (live(s)) drop_for_add(s);
        end
        s = by_node(id);
        if (live(s)) drop_for_add(s);
        if (live(free_top)) begin
            ins      = free_top;
            free_top = older[ins];
        end else begin
            ins = oldest;
            if (!live(ins)) begin
                owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
                return;
            end
            unlink(ins);
            used[ins] = 0;
            if (notice_en)
                owe(lbac_pkg::KIND_NOTICE, 0, node_of[ins], shown(alias_of[ins]));
        end
        keep          = nr ? (lbac_pkg::NR_ALIAS | lbac_pkg::alias_t'(ins)) : a;
        node_of[ins]  = id;
        alias_of[ins] = keep;
        used[ins]     = 1;
        make_newest(ins);
        owe(lbac_pkg::KIND_ANSWER, 1, id, shown(keep));
    endfunction

    function lbac_pkg::alias_t next_alias();
        lbac_pkg::id_t    sd;
        lbac_pkg::alias_t a;
        lbac_pkg::link_t  s;
        forever begin
            sd   = seed;
            a    = lbac_pkg::alias_t'((sd ^ (sd >> 12) ^ (sd >> 24) ^ (sd >> 36)) & 48'hFFF);
            seed = sd * 48'd513 + lbac_pkg::GEN_ADD;
            if (a != 0) begin
                s = by_alias(a);
                if (!live(s)) return a;
                touch(s);
            end
        end
    endfunction

    // work out every reply an accepted item causes
    function void note_input(lbac_pkg::cmd_t cmd, lbac_pkg::id_t id, lbac_pkg::alias_t a,
                             lbac_pkg::slot_t idx);
        lbac_pkg::link_t s;
        case (cmd)
            lbac_pkg::CMD_ADD: add_entry(id, a);
            lbac_pkg::CMD_REMOVE: begin
                s = by_alias(a);
                if (live(s)) begin
                    owe(lbac_pkg::KIND_ANSWER, 1, node_of[s], shown(alias_of[s]));
                    release_slot(s);
                end else owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            end
            lbac_pkg::CMD_LOOKUP_ID, lbac_pkg::CMD_LOOKUP_ALIAS: begin
                s = (cmd == lbac_pkg::CMD_LOOKUP_ID) ? by_node(id) : by_alias(a);
                if (live(s)) begin
                    touch(s);
                    owe(lbac_pkg::KIND_ANSWER, 1, node_of[s], shown(alias_of[s]));
                end else owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            end
            lbac_pkg::CMD_RETRIEVE: begin
                if (alias_of[idx] != 0)
                    owe(lbac_pkg::KIND_ANSWER, 1, node_of[idx], shown(alias_of[idx]));
                else owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            end
            lbac_pkg::CMD_NEXT_ID: begin
                s = lbac_pkg::NO_LINK;
                for (int i = 0; i < lbac_pkg::POOL_ENTRIES; i++)
                    if (used[i] && node_of[i] > id &&
                        (!live(s) || node_of[i] < node_of[s]))
                        s = lbac_pkg::link_t'(i);
                if (live(s)) owe(lbac_pkg::KIND_ANSWER, 1, node_of[s], shown(alias_of[s]));
                else owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            end
            lbac_pkg::CMD_GENERATE: owe(lbac_pkg::KIND_ANSWER, 0, '0, next_alias());
            default: begin
                rebuild();
                owe(lbac_pkg::KIND_ANSWER, 0, '0, '0);
            end
        endcase
        owed[owed.size() - 1].last = 1;
    endfunction

    function void check_reply(cache_reply_t got);
        cache_reply_t want;
        if (owed.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected reply kind=%0d found=%0d id=%h alias=%h last=%0d",
                         got.kind, got.found, got.node, got.name, got.last);
            return;
        end
        want = owed.pop_front();
        if (want != got) begin
            errors++;
            if (errors <= 10)
                $display("reply mismatch: expected kind=%0d found=%0d id=%h alias=%h last=%0d, %s",
                         want.kind, want.found, want.node, want.name, want.last,
                         $sformatf("got kind=%0d found=%0d id=%h alias=%h last=%0d",
                                   got.kind, got.found, got.node, got.name, got.last));
        end
    endfunction
endclass

module lru_bidirectional_alias_cache_core_tb;

    logic        aclk      = 0;
    logic        aresetn   = 0;
    logic        s_tvalid  = 0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;  // node_id[47:0], alias_req[63:48], slot_index[68:64]
    logic [2:0]  s_tuser   = '0;  // command[2:0]
    logic        m_tvalid;
    logic        m_tready  = 0;
    logic [71:0] m_tdata;         // found[0], out_node_id[48:1], out_alias[64:49]
    logic        m_tuser;         // kind[0]
    logic        m_tlast;
    logic        cfg_we    = 0;
    logic        cfg_index = 0;
    logic [47:0] cfg_wdata = '0;

    alias_cache_scoreboard cache_sb = new();

    // idle percentages for the sender and the receiver
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;

    lru_bidirectional_alias_cache_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // result side: check each accepted item, then pick the next ready level
    always @(posedge aclk) begin
        cache_reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.found = m_tdata[0];
            got.node  = m_tdata[48:1];
            got.name  = m_tdata[64:49];
            got.last  = m_tlast;
            cache_sb.check_reply(got);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one item on the input channel, with a random gap ahead of it
    task automatic send_item(lbac_pkg::cmd_t cmd, lbac_pkg::id_t id, lbac_pkg::alias_t a,
                             lbac_pkg::slot_t idx);
        int gap;
        gap = 0;
        if (send_gap_pct != 0)
            while ($urandom_range(99) < send_gap_pct && gap < 20) gap++;
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, idx, a, id};
        do @(posedge aclk); while (!s_tready);
        cache_sb.note_input(cmd, id, a, idx);
    endtask

    // hold the sender until the block has caught up
    task automatic drain();
        s_tvalid <= 0;
        while (cache_sb.owed.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, lbac_pkg::id_t val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        cache_sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    function automatic lbac_pkg::id_t pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 80) return lbac_pkg::id_t'($urandom_range(1, 48));
        if (r < 95) return lbac_pkg::id_t'({$urandom, $urandom});
        return '0;
    endfunction

    function automatic lbac_pkg::alias_t pick_alias();
        int r;
        r = $urandom_range(99);
        if (r < 70) return lbac_pkg::alias_t'($urandom_range(1, 48));
        if (r < 82) return lbac_pkg::NR_ALIAS | lbac_pkg::alias_t'($urandom_range(0, 4095));
        if (r < 96) return lbac_pkg::alias_t'($urandom);
        return '0;
    endfunction

    // random items, adds weighted so the pool fills and evicts
    task automatic random_items(int count);
        lbac_pkg::cmd_t cmd;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 45) cmd = lbac_pkg::CMD_ADD;
            else cmd = lbac_pkg::cmd_t'($urandom_range(1, 7));
            if (cmd == lbac_pkg::CMD_CLEAR && $urandom_range(3) != 0)
                cmd = lbac_pkg::CMD_LOOKUP_ALIAS;
            send_item(cmd, pick_id(), pick_alias(), lbac_pkg::slot_t'($urandom_range(31)));
            // one mid-phase pause until every reply is back
            if (i == count / 2) drain();
        end
    endtask

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        cache_sb.power_up();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, every command and the corner cases
        send_item(lbac_pkg::CMD_ADD, 48'd1, 16'd1, '0);
        send_item(lbac_pkg::CMD_ADD, 48'hFFFF_FFFF_FFFF, 16'h0FFF, '0);
        send_item(lbac_pkg::CMD_ADD, 48'd0, 16'd3, '0);     // zero id is ignored
        send_item(lbac_pkg::CMD_ADD, 48'd4, 16'd0, '0);     // zero alias is ignored
        send_item(lbac_pkg::CMD_ADD, 48'd5, lbac_pkg::NR_ALIAS, '0);  // not responding
        send_item(lbac_pkg::CMD_ADD, 48'd6, 16'hFABC, '0);  // top nibble F counts as not responding
        send_item(lbac_pkg::CMD_ADD, 48'd7, 16'd1, '0);     // same alias drops id 1
        send_item(lbac_pkg::CMD_ADD, 48'd7, 16'd2, '0);     // same id drops the previous one
        send_item(lbac_pkg::CMD_LOOKUP_ID, 48'd5, '0, '0);
        send_item(lbac_pkg::CMD_LOOKUP_ALIAS, '0, 16'hF01C, '0);  // stored not-responding form
        send_item(lbac_pkg::CMD_LOOKUP_ALIAS, '0, 16'hFFFF, '0);
        send_item(lbac_pkg::CMD_LOOKUP_ALIAS, '0, 16'd0, '0);     // alias zero never matches
        send_item(lbac_pkg::CMD_REMOVE, '0, 16'd2, '0);
        send_item(lbac_pkg::CMD_REMOVE, '0, 16'd2, '0);     // miss
        send_item(lbac_pkg::CMD_RETRIEVE, '0, '0, 5'd31);   // removed slot keeps its alias
        send_item(lbac_pkg::CMD_RETRIEVE, '0, '0, 5'd0);    // never written
        send_item(lbac_pkg::CMD_NEXT_ID, 48'd0, '0, '0);
        send_item(lbac_pkg::CMD_NEXT_ID, 48'hFFFF_FFFF_FFFF, '0, '0);
        send_item(lbac_pkg::CMD_GENERATE, '0, '0, '0);
        send_item(lbac_pkg::CMD_GENERATE, '0, '0, '0);
        send_item(lbac_pkg::CMD_CLEAR, '0, '0, '0);
        send_item(lbac_pkg::CMD_RETRIEVE, '0, '0, 5'd30);   // stale data after clear
        send_item(lbac_pkg::CMD_LOOKUP_ID, 48'hFFFF_FFFF_FFFF, '0, '0);
        drain();

        // random phases, each with its own idling pattern and settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
                default: begin send_gap_pct = 28; recv_stall_pct = 28; end
            endcase
            case (ph)
                0: write_reg(lbac_pkg::CFG_NOTICE, 48'd0);
                1: begin
                    write_reg(lbac_pkg::CFG_NOTICE, 48'd1);
                    write_reg(lbac_pkg::CFG_SEED, 48'hFFFF_FFFF_FFFF);
                end
                2: write_reg(lbac_pkg::CFG_SEED, lbac_pkg::id_t'({$urandom, $urandom}));
                default: write_reg(lbac_pkg::CFG_SEED, 48'd0);
            endcase
            random_items(22);
            drain();
        end

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        if (cache_sb.errors == 0 && cache_sb.owed.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/lbac_pkg.sv
src/lbac_ram.sv
src/lru_bidirectional_alias_cache_core.sv
test/lru_bidirectional_alias_cache_core_tb.sv
